[rtl/dlm_pkg.sv]
// Shared constants for the byte digraph log map.
// No dependencies.
package dlm_pkg;
   localparam int MapSide   = 256;
   localparam int CountBits = 32;
   localparam int ByteBits  = 8;
   localparam int CellBits  = $clog2(MapSide * MapSide);
   localparam int FracBits  = 11;
   localparam int ExpBits   = 5;
   localparam int LogBits   = ExpBits + FracBits + 1;
   localparam int MantBits  = 16;
   localparam int StepBits  = 4;
   localparam int QuotBits  = 9;
   localparam int NumBits   = LogBits + ByteBits + 1;

   localparam logic [CountBits-1:0] CountLimit  = {CountBits{1'b1}};
   localparam logic [7:0]           GrayFull    = 8'd255;
   localparam logic [31:0]          OpaqueAlpha = 32'hFF00_0000;

   localparam logic [1:0] ModeClear = 2'd0;
   localparam logic [1:0] ModeData  = 2'd1;
   localparam logic [1:0] ModeRead  = 2'd2;
endpackage

[rtl/dlm_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module dlm_ram #(
   parameter int Width = 32,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

[rtl/dlm_log2.sv]
// Iterative fixed-point log2 (Q6.11), one squaring step per cycle.
// Depends on dlm_pkg.
module dlm_log2 (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [dlm_pkg::CountBits-1:0] value,
   output logic                          done,
   output logic [dlm_pkg::LogBits-1:0]   result
);
   logic [dlm_pkg::ExpBits-1:0]  exp_in, exp_ff;
   logic [dlm_pkg::MantBits-1:0] x_in, x_ff, x_next;
   logic [dlm_pkg::FracBits-1:0] frac_ff;
   logic [dlm_pkg::StepBits-1:0] step_ff;
   logic                         busy_ff, done_ff;
   logic [2*dlm_pkg::MantBits-1:0] sq;
   logic [dlm_pkg::MantBits:0]     sq_top;

   // leading one and normalized mantissa
   always_comb begin
      exp_in = '0;
      for (int i = 0; i < dlm_pkg::CountBits; i++) begin
         if (value[i]) begin
            exp_in = dlm_pkg::ExpBits'(i);
         end
      end
      if (exp_in >= dlm_pkg::ExpBits'(dlm_pkg::MantBits - 1)) begin
         x_in = dlm_pkg::MantBits'(value >> (exp_in - dlm_pkg::ExpBits'(dlm_pkg::MantBits - 1)));
      end else begin
         x_in = dlm_pkg::MantBits'(value << (dlm_pkg::ExpBits'(dlm_pkg::MantBits - 1) - exp_in));
      end
   end

   assign sq     = x_ff * x_ff;
   assign sq_top = sq[2*dlm_pkg::MantBits-1:dlm_pkg::MantBits-1];
   assign x_next = sq_top[dlm_pkg::MantBits] ? sq_top[dlm_pkg::MantBits:1]
                                             : sq_top[dlm_pkg::MantBits-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
            exp_ff  <= exp_in;
            x_ff    <= x_in;
            frac_ff <= '0;
         end else if (busy_ff) begin
            x_ff    <= x_next;
            frac_ff <= {frac_ff[dlm_pkg::FracBits-2:0], sq_top[dlm_pkg::MantBits]};
            step_ff <= step_ff + 1'b1;
            if (step_ff == dlm_pkg::StepBits'(dlm_pkg::FracBits - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done   = done_ff;
   assign result = {1'b0, exp_ff, frac_ff};
endmodule

[rtl/byte_digraph_log_map.sv]
// Byte digraph map top level: count memory, sequencer and log read-out.
// Depends on dlm_pkg, dlm_ram and dlm_log2.
//
// Consecutive stream bytes count into a 65536-entry map held in one RAM.
// After reset the map is zeroed by a sweep over all 65536 entries, one
// entry per cycle, with req_stall high; a clear item, once accepted, runs
// the same sweep. A data item reads the RAM on accept and writes the bumped
// count back in StData; the first byte after reset or a clear only records
// the byte. A read item reads the RAM on accept, takes the count in StRead,
// does two log2 runs on the shared squaring unit, a 9-step restoring divide
// and loads the result register in StDone; it skips the log2 runs and the
// divide when the count or the largest count is below 2. A held result
// stalls the next read in StDone until it is taken. Unused mode 3 does nothing.
module byte_digraph_log_map (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [7:0]  req_data_byte,
   input  logic [7:0]  req_read_row,
   input  logic [7:0]  req_read_col,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_gray_level,
   output logic [31:0] rsp_rgba_word,
   output logic [31:0] rsp_cell_count
);
   typedef enum logic [3:0] {
      StClear, StIdle, StData, StRead, StLogC, StLogM, StDiv, StDone
   } state_type;

   state_type state_ff;
   logic [dlm_pkg::CellBits-1:0]  sweep_ff, wr_addr_ff, rd_addr;
   logic [dlm_pkg::ByteBits-1:0]  prev_ff;
   logic                          have_prev_ff;
   logic [dlm_pkg::CountBits-1:0] max_ff, count_ff, rd_data, bumped;
   logic                          wr_en;
   logic [dlm_pkg::CellBits-1:0]  wr_addr;
   logic [dlm_pkg::CountBits-1:0] wr_data;
   logic                          log_start, log_done;
   logic [dlm_pkg::CountBits-1:0] log_value;
   logic [dlm_pkg::LogBits-1:0]   log_result, lc_ff, lm_ff;
   logic [dlm_pkg::NumBits-1:0]   rem_ff, div_sub;
   logic [dlm_pkg::QuotBits-1:0]  quot_ff;
   logic [dlm_pkg::StepBits-1:0]  div_step_ff;
   logic                          accept;
   logic                          rsp_valid_ff;
   logic [7:0]                    gray_ff;
   logic [dlm_pkg::CountBits-1:0] rsp_count_ff;

   assign accept  = req_valid && (state_ff == StIdle);
   assign rd_addr = (req_mode == dlm_pkg::ModeData) ? {req_data_byte, prev_ff}
                                                    : {req_read_row, req_read_col};
   assign bumped  = (rd_data == dlm_pkg::CountLimit) ? rd_data : rd_data + 1'b1;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = wr_addr_ff;
      wr_data = bumped;
      if (state_ff == StClear) begin
         wr_en   = 1'b1;
         wr_addr = sweep_ff;
         wr_data = '0;
      end else if (state_ff == StData) begin
         wr_en = 1'b1;
      end
   end

   dlm_ram #(
      .Width(dlm_pkg::CountBits),
      .Depth(dlm_pkg::MapSide * dlm_pkg::MapSide)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign log_start = (state_ff == StRead) || (state_ff == StLogC && log_done);
   assign log_value = (state_ff == StRead) ? rd_data : max_ff;

   dlm_log2 u_log (
      .clock  (clock),
      .reset  (reset),
      .start  (log_start),
      .value  (log_value),
      .done   (log_done),
      .result (log_result)
   );

   assign div_sub = dlm_pkg::NumBits'(lm_ff) << div_step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StClear;
         sweep_ff     <= '0;
         prev_ff      <= '0;
         have_prev_ff <= 1'b0;
         max_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == StDone && (!rsp_valid_ff || !rsp_stall)) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            StClear: begin
               sweep_ff <= sweep_ff + 1'b1;
               if (sweep_ff == '1) begin
                  state_ff <= StIdle;
               end
            end
            StIdle: begin
               if (accept) begin
                  wr_addr_ff <= rd_addr;
                  if (req_mode == dlm_pkg::ModeClear) begin
                     state_ff     <= StClear;
                     sweep_ff     <= '0;
                     prev_ff      <= '0;
                     have_prev_ff <= 1'b0;
                     max_ff       <= '0;
                  end else if (req_mode == dlm_pkg::ModeData) begin
                     prev_ff      <= req_data_byte;
                     have_prev_ff <= 1'b1;
                     if (have_prev_ff) begin
                        state_ff <= StData;
                     end
                  end else if (req_mode == dlm_pkg::ModeRead) begin
                     state_ff <= StRead;
                  end
               end
            end
            StData: begin
               if (bumped > max_ff) begin
                  max_ff <= bumped;
               end
               state_ff <= StIdle;
            end
            StRead: begin
               count_ff <= rd_data;
               quot_ff  <= '0;
               if (rd_data < 2 || max_ff < 2) begin
                  state_ff <= StDone;
               end else begin
                  state_ff <= StLogC;
               end
            end
            StLogC: begin
               if (log_done) begin
                  lc_ff    <= log_result;
                  state_ff <= StLogM;
               end
            end
            StLogM: begin
               if (log_done) begin
                  lm_ff       <= log_result;
                  rem_ff      <= (dlm_pkg::NumBits'(lc_ff) << 8) - dlm_pkg::NumBits'(lc_ff);
                  div_step_ff <= dlm_pkg::StepBits'(dlm_pkg::QuotBits - 1);
                  state_ff    <= StDiv;
               end
            end
            StDiv: begin
               if (rem_ff >= div_sub) begin
                  rem_ff  <= rem_ff - div_sub;
                  quot_ff <= {quot_ff[dlm_pkg::QuotBits-2:0], 1'b1};
               end else begin
                  quot_ff <= {quot_ff[dlm_pkg::QuotBits-2:0], 1'b0};
               end
               div_step_ff <= div_step_ff - 1'b1;
               if (div_step_ff == '0) begin
                  state_ff <= StDone;
               end
            end
            StDone: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_count_ff <= count_ff;
                  gray_ff      <= quot_ff[dlm_pkg::QuotBits-1] ? dlm_pkg::GrayFull
                                                               : quot_ff[7:0];
                  state_ff     <= StIdle;
               end
            end
            default: state_ff <= StIdle;
         endcase
      end
   end

   assign req_stall      = (state_ff != StIdle);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_gray_level = gray_ff;
   assign rsp_rgba_word  = dlm_pkg::OpaqueAlpha | {8'd0, gray_ff, gray_ff, gray_ff};
   assign rsp_cell_count = 32'(rsp_count_ff);
endmodule
